// ----- rtl/core/zap_pkg.sv -----
// Shared types, constants and helpers of the zone allocation policy core.
`default_nettype none
package zap_pkg;

    localparam int ZONE_COUNT = 64;
    localparam int ZONE_W     = 6;
    localparam int CAP_W      = 21;
    localparam int CNT_W      = 7;
    localparam int CMD_W      = 3;
    localparam int HINT_W     = 3;
    localparam int STAT_W     = 3;
    localparam int THR_W      = 22;
    localparam int PROD_W     = 28;
    localparam int MULT_W     = 57;

    // floor(p / 100) for p below 2^28 as (p * RECIP_K) >> RECIP_SHIFT
    localparam logic [MULT_W-1:0] RECIP_K     = MULT_W'(343597384);
    localparam int                RECIP_SHIFT = 35;

    localparam logic [CAP_W-1:0]  ZONE_RESET_FREE = CAP_W'(1048576);
    localparam logic [CAP_W-1:0]  CAP_MAX         = {CAP_W{1'b1}};
    localparam logic [CNT_W-1:0]  CNT_MAX         = {CNT_W{1'b1}};
    localparam logic [CNT_W-1:0]  DIFF_BAD        = CNT_W'(100);
    localparam logic [CNT_W-1:0]  ZONE_TOTAL      = CNT_W'(ZONE_COUNT);
    localparam logic [ZONE_W-1:0] LAST_ZONE       = ZONE_W'(ZONE_COUNT - 1);
    localparam logic [HINT_W-1:0] HINT_MAX        = HINT_W'(5);

    // commands
    localparam logic [CMD_W-1:0] CMD_ALLOC     = 3'd0;
    localparam logic [CMD_W-1:0] CMD_APPEND    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_CLOSE     = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SET_USED  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_RESET_UNU = 3'd4;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK         = 3'd0;
    localparam logic [STAT_W-1:0] ST_NO_ZONE    = 3'd1;
    localparam logic [STAT_W-1:0] ST_OPEN_LIMIT = 3'd2;
    localparam logic [STAT_W-1:0] ST_NO_SPACE   = 3'd3;
    localparam logic [STAT_W-1:0] ST_BAD        = 3'd4;

    // configuration register indexes
    localparam logic [2:0] REG_FINISH_THR = 3'd0;
    localparam logic [2:0] REG_MAX_ACTIVE = 3'd1;
    localparam logic [2:0] REG_MAX_OPEN   = 3'd2;
    localparam logic [2:0] REG_PROT_LIMIT = 3'd3;
    localparam logic [2:0] REG_ZONE_CAP   = 3'd4;

    typedef struct packed {
        logic [CAP_W-1:0]  free_blocks;
        logic [CAP_W-1:0]  written_blocks;
        logic [CAP_W-1:0]  used_blocks;
        logic              open_flag;
        logic [HINT_W-1:0] lifetime;
        logic              prot_flag;
    } zone_rec_t;

    typedef struct packed {
        logic [CNT_W-1:0] finish_threshold;
        logic [CNT_W-1:0] max_active_zones;
        logic [CNT_W-1:0] max_open_zones;
        logic [CNT_W-1:0] protected_zone_limit;
        logic [CAP_W-1:0] zone_capacity;
    } cfg_t;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [HINT_W-1:0] lifetime_hint;
        logic              protected_request;
        logic [ZONE_W-1:0] zone_index;
        logic [CAP_W-1:0]  block_count;
    } req_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [ZONE_W-1:0] chosen_zone;
        logic              was_empty_zone;
        logic              flush_issued;
        logic [CAP_W-1:0]  capacity_left;
        logic [CNT_W-1:0]  active_count;
        logic [CNT_W-1:0]  open_count;
    } result_t;

    function automatic logic [CNT_W-1:0] sat_dec(input logic [CNT_W-1:0] v);
        logic [CNT_W-1:0] r;
        r = (v == '0) ? v : v - CNT_W'(1);
        return r;
    endfunction

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        logic [CNT_W-1:0] r;
        r = (v == CNT_MAX) ? v : v + CNT_W'(1);
        return r;
    endfunction

    function automatic logic [CNT_W-1:0] lifetime_diff(input logic [HINT_W-1:0] zl,
                                                       input logic [HINT_W-1:0] fl);
        logic [CNT_W-1:0] r;
        if (fl <= HINT_W'(1)) begin
            r = (fl == zl) ? '0 : DIFF_BAD;
        end else if (zl > fl) begin
            r = CNT_W'(zl - fl);
        end else begin
            r = DIFF_BAD;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/core/zone_allocation_policy_core.sv -----
// Zone allocation policy core: configuration, stream ports, output register.
//
// Bookkeeping for a zoned store of 64 zones. One command word enters on the
// s_ channel (command in s_tuser), one result word leaves on the m_ channel.
// Registers are written through cfg_wr_en / cfg_index / cfg_wdata; the user
// must do so only while idle, as the block does not enforce it. Every zone
// record lives in one RAM with a single read-modify-write path, and each
// record visit is a read followed by an update. Append, close and set used
// visit one record, reset unused visits all 64, and allocate sweeps the
// zones and visits the protected list entries that it walks.
// One command is worked at a time; s_tready is high only while the sequencer
// waits for a word. A finished result sits in the output register, so the
// next word is taken while m_tvalid waits for m_tready; a second result
// waits in the sequencer until the register frees up.
// Reset (aresetn low, synchronous) restores the register defaults, clears
// all counters and the protected list, and marks every zone record empty
// at full capacity at once; no clearing pass follows.
`default_nettype none
module zone_allocation_policy_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // lifetime_hint[2:0], protected_request[3], zone_index[9:4],
    // block_count[30:10], zero[31]
    input  wire logic [31:0] s_tdata,
    // command[2:0]
    input  wire logic [2:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // status[2:0], chosen_zone[8:3], was_empty_zone[9], flush_issued[10],
    // capacity_left[31:11], active_count[38:32], open_count[45:39], zero[47:46]
    output logic [47:0]      m_tdata,
    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [20:0] cfg_wdata
);
    zap_pkg::cfg_t      cfg_reg;
    zap_pkg::req_t      req;
    zap_pkg::result_t   res;
    zap_pkg::zone_rec_t st_rd_rec;
    zap_pkg::zone_rec_t st_wr_rec;
    logic                       res_valid;
    logic                       res_ready;
    logic [zap_pkg::ZONE_W-1:0] st_rd_addr;
    logic                       st_wr_en;
    logic [zap_pkg::ZONE_W-1:0] st_wr_addr;
    logic [zap_pkg::ZONE_W-1:0] ord_rd_addr;
    logic [zap_pkg::ZONE_W-1:0] ord_rd_data;
    logic                       ord_wr_en;
    logic [zap_pkg::ZONE_W-1:0] ord_wr_addr;
    logic [zap_pkg::ZONE_W-1:0] ord_wr_data;
    logic                       m_valid_reg;
    logic [47:0]                m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.finish_threshold     <= '0;
            cfg_reg.max_active_zones     <= zap_pkg::CNT_W'(64);
            cfg_reg.max_open_zones       <= zap_pkg::CNT_W'(64);
            cfg_reg.protected_zone_limit <= '0;
            cfg_reg.zone_capacity        <= zap_pkg::ZONE_RESET_FREE;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                zap_pkg::REG_FINISH_THR: cfg_reg.finish_threshold     <= cfg_wdata[6:0];
                zap_pkg::REG_MAX_ACTIVE: cfg_reg.max_active_zones     <= cfg_wdata[6:0];
                zap_pkg::REG_MAX_OPEN:   cfg_reg.max_open_zones       <= cfg_wdata[6:0];
                zap_pkg::REG_PROT_LIMIT: cfg_reg.protected_zone_limit <= cfg_wdata[6:0];
                zap_pkg::REG_ZONE_CAP:   cfg_reg.zone_capacity        <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        req.command           = s_tuser;
        req.lifetime_hint     = s_tdata[2:0];
        req.protected_request = s_tdata[3];
        req.zone_index        = s_tdata[9:4];
        req.block_count       = s_tdata[30:10];
    end

    zap_zone_store u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_addr (st_rd_addr),
        .rd_rec  (st_rd_rec),
        .wr_en   (st_wr_en),
        .wr_addr (st_wr_addr),
        .wr_rec  (st_wr_rec)
    );

    zap_ram #(
        .WIDTH (zap_pkg::ZONE_W),
        .DEPTH (zap_pkg::ZONE_COUNT)
    ) u_order_ram (
        .aclk    (aclk),
        .wr_en   (ord_wr_en),
        .wr_addr (ord_wr_addr),
        .wr_data (ord_wr_data),
        .rd_addr (ord_rd_addr),
        .rd_data (ord_rd_data)
    );

    zap_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_req      (req),
        .in_ready    (s_tready),
        .cfg         (cfg_reg),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .st_rd_addr  (st_rd_addr),
        .st_rd_rec   (st_rd_rec),
        .st_wr_en    (st_wr_en),
        .st_wr_addr  (st_wr_addr),
        .st_wr_rec   (st_wr_rec),
        .ord_rd_addr (ord_rd_addr),
        .ord_rd_data (ord_rd_data),
        .ord_wr_en   (ord_wr_en),
        .ord_wr_addr (ord_wr_addr),
        .ord_wr_data (ord_wr_data)
    );

    // take a new word whenever the output register is empty or being drained
    assign res_ready = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            m_data_reg <= {2'b00, res.open_count, res.active_count, res.capacity_left,
                           res.flush_issued, res.was_empty_zone, res.chosen_zone,
                           res.status};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    a_idle_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !res_valid)
        else $error("sequencer takes a word while holding a result");

    a_fresh_only_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[9] |-> m_tdata[2:0] == zap_pkg::ST_OK)
        else $error("empty zone flagged on a failed command");

    a_no_pick_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[2:0] == zap_pkg::ST_NO_ZONE ||
                     m_tdata[2:0] == zap_pkg::ST_OPEN_LIMIT)
        |-> m_tdata[8:3] == '0 && m_tdata[31:11] == '0)
        else $error("zone or capacity reported without a chosen zone");
endmodule
`default_nettype wire

// ----- rtl/core/zap_ram.sv -----
// Generic single write port RAM with registered read.
`default_nettype none
module zap_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule
`default_nettype wire

// ----- rtl/core/zap_zone_store.sv -----
// Per-zone record store: RAM plus valid bits that stand in for the reset contents.
`default_nettype none
module zap_zone_store (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic [zap_pkg::ZONE_W-1:0] rd_addr,
    output zap_pkg::zone_rec_t             rd_rec,
    input  wire logic                      wr_en,
    input  wire logic [zap_pkg::ZONE_W-1:0] wr_addr,
    input  zap_pkg::zone_rec_t             wr_rec
);
    logic [zap_pkg::ZONE_COUNT-1:0] valid_reg;
    logic                           rvalid_reg;
    zap_pkg::zone_rec_t             ram_q;
    zap_pkg::zone_rec_t             reset_rec;

    zap_ram #(
        .WIDTH ($bits(zap_pkg::zone_rec_t)),
        .DEPTH (zap_pkg::ZONE_COUNT)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_rec),
        .rd_addr (rd_addr),
        .rd_data (ram_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            rvalid_reg <= valid_reg[rd_addr];
        end
    end

    always_comb begin
        reset_rec             = '0;
        reset_rec.free_blocks = zap_pkg::ZONE_RESET_FREE;
        rd_rec                = rvalid_reg ? ram_q : reset_rec;
    end
endmodule
`default_nettype wire

// ----- rtl/core/zap_ctrl.sv -----
// Sequencer: walks zone records through one read-modify-write unit per command.
`default_nettype none
module zap_ctrl (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       in_valid,
    input  zap_pkg::req_t                   in_req,
    output logic                            in_ready,
    input  zap_pkg::cfg_t                   cfg,
    output logic                            res_valid,
    input  wire logic                       res_ready,
    output zap_pkg::result_t                res,
    output logic [zap_pkg::ZONE_W-1:0]      st_rd_addr,
    input  zap_pkg::zone_rec_t              st_rd_rec,
    output logic                            st_wr_en,
    output logic [zap_pkg::ZONE_W-1:0]      st_wr_addr,
    output zap_pkg::zone_rec_t              st_wr_rec,
    output logic [zap_pkg::ZONE_W-1:0]      ord_rd_addr,
    input  wire logic [zap_pkg::ZONE_W-1:0] ord_rd_data,
    output logic                            ord_wr_en,
    output logic [zap_pkg::ZONE_W-1:0]      ord_wr_addr,
    output logic [zap_pkg::ZONE_W-1:0]      ord_wr_data
);
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MUL1 = 4'd1;
    localparam logic [3:0] S_MUL2 = 4'd2;
    localparam logic [3:0] S_ZRD  = 4'd3;
    localparam logic [3:0] S_EX   = 4'd4;
    localparam logic [3:0] S_ORD  = 4'd5;
    localparam logic [3:0] S_ORDW = 4'd6;
    localparam logic [3:0] S_POST = 4'd7;
    localparam logic [3:0] S_VCHK = 4'd8;
    localparam logic [3:0] S_ECHK = 4'd9;
    localparam logic [3:0] S_FIN  = 4'd10;
    localparam logic [3:0] S_DONE = 4'd11;

    localparam logic [3:0] PH_CMD   = 4'd0;
    localparam logic [3:0] PH_RST   = 4'd1;
    localparam logic [3:0] PH_SW1   = 4'd2;
    localparam logic [3:0] PH_PLIST = 4'd3;
    localparam logic [3:0] PH_PCLR  = 4'd4;
    localparam logic [3:0] PH_VIC   = 4'd5;
    localparam logic [3:0] PH_LIFE  = 4'd6;
    localparam logic [3:0] PH_EMPTY = 4'd7;
    localparam logic [3:0] PH_OPEN  = 4'd8;

    logic [3:0] state_reg, state_next;
    logic [3:0] phase_reg, phase_next;

    logic [zap_pkg::CNT_W-1:0]  active_reg, active_next;
    logic [zap_pkg::CNT_W-1:0]  open_reg, open_next;
    logic [zap_pkg::CNT_W-1:0]  plen_reg, plen_next;

    zap_pkg::req_t              req_reg, req_next;
    logic [zap_pkg::ZONE_W-1:0] zaddr_reg, zaddr_next;
    logic [zap_pkg::CNT_W-1:0]  idx_reg, idx_next;
    logic [zap_pkg::ZONE_W-1:0] victim_reg, victim_next;
    logic [zap_pkg::CAP_W-1:0]  vfree_reg, vfree_next;
    logic                       hv_reg, hv_next;
    logic [zap_pkg::ZONE_W-1:0] pick_reg, pick_next;
    logic                       found_reg, found_next;
    logic                       fresh_reg, fresh_next;
    logic                       flush_reg, flush_next;
    logic                       havepick_reg, havepick_next;
    logic [zap_pkg::CNT_W-1:0]  best_reg, best_next;
    logic [zap_pkg::THR_W-1:0]  thr_reg, thr_next;
    logic [zap_pkg::PROD_W-1:0] prod_reg, prod_next;
    logic [zap_pkg::STAT_W-1:0] status_reg, status_next;
    logic [zap_pkg::CAP_W-1:0]  capout_reg, capout_next;

    zap_pkg::zone_rec_t rec;
    zap_pkg::zone_rec_t wrec;
    logic               zwe;
    logic               owe;

    assign st_rd_addr  = zaddr_reg;
    assign st_wr_addr  = zaddr_reg;
    assign st_wr_en    = zwe;
    assign st_wr_rec   = wrec;
    assign ord_rd_addr = idx_reg[zap_pkg::ZONE_W-1:0];
    assign ord_wr_addr = plen_reg[zap_pkg::ZONE_W-1:0];
    assign ord_wr_data = zaddr_reg;
    assign ord_wr_en   = owe;
    assign rec         = st_rd_rec;

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);

    always_comb begin
        res.status         = status_reg;
        res.chosen_zone    = havepick_reg ? pick_reg : '0;
        res.was_empty_zone = fresh_reg;
        res.flush_issued   = flush_reg;
        res.capacity_left  = havepick_reg ? capout_reg : '0;
        res.active_count   = active_reg;
        res.open_count     = open_reg;
    end

    always_comb begin
        logic                        last;
        logic [zap_pkg::CAP_W:0]     wsum;
        logic [zap_pkg::CAP_W-1:0]   nf;
        logic [zap_pkg::CNT_W-1:0]   d;
        logic [zap_pkg::CNT_W-1:0]   bnew;
        logic [zap_pkg::MULT_W-1:0]  qprod;

        state_next    = state_reg;
        phase_next    = phase_reg;
        active_next   = active_reg;
        open_next     = open_reg;
        plen_next     = plen_reg;
        req_next      = req_reg;
        zaddr_next    = zaddr_reg;
        idx_next      = idx_reg;
        victim_next   = victim_reg;
        vfree_next    = vfree_reg;
        hv_next       = hv_reg;
        pick_next     = pick_reg;
        found_next    = found_reg;
        fresh_next    = fresh_reg;
        flush_next    = flush_reg;
        havepick_next = havepick_reg;
        best_next     = best_reg;
        thr_next      = thr_reg;
        prod_next     = prod_reg;
        status_next   = status_reg;
        capout_next   = capout_reg;
        wrec          = rec;
        zwe           = 1'b0;
        owe           = 1'b0;
        last          = (zaddr_reg == zap_pkg::LAST_ZONE);
        wsum          = '0;
        nf            = rec.free_blocks;
        d             = zap_pkg::DIFF_BAD;
        bnew          = best_reg;
        qprod         = zap_pkg::MULT_W'(prod_reg) * zap_pkg::RECIP_K;

        unique case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    req_next      = in_req;
                    zaddr_next    = in_req.zone_index;
                    found_next    = 1'b0;
                    fresh_next    = 1'b0;
                    flush_next    = 1'b0;
                    hv_next       = 1'b0;
                    havepick_next = 1'b0;
                    pick_next     = '0;
                    capout_next   = '0;
                    status_next   = zap_pkg::ST_OK;
                    priority if (in_req.command == zap_pkg::CMD_ALLOC) begin
                        if (in_req.lifetime_hint > zap_pkg::HINT_MAX) begin
                            status_next = zap_pkg::ST_BAD;
                            state_next  = S_DONE;
                        end else if (open_reg >= cfg.max_open_zones) begin
                            status_next = zap_pkg::ST_OPEN_LIMIT;
                            state_next  = S_DONE;
                        end else begin
                            state_next = S_MUL1;
                        end
                    end else if (in_req.command == zap_pkg::CMD_APPEND ||
                                 in_req.command == zap_pkg::CMD_CLOSE ||
                                 in_req.command == zap_pkg::CMD_SET_USED) begin
                        phase_next = PH_CMD;
                        state_next = S_ZRD;
                    end else if (in_req.command == zap_pkg::CMD_RESET_UNU) begin
                        zaddr_next = '0;
                        phase_next = PH_RST;
                        state_next = S_ZRD;
                    end else begin
                        status_next = zap_pkg::ST_BAD;
                        state_next  = S_DONE;
                    end
                end
            end
            S_MUL1: begin
                prod_next  = zap_pkg::PROD_W'(cfg.zone_capacity) *
                             zap_pkg::PROD_W'(cfg.finish_threshold);
                state_next = S_MUL2;
            end
            S_MUL2: begin
                thr_next   = zap_pkg::THR_W'(qprod >> zap_pkg::RECIP_SHIFT);
                zaddr_next = '0;
                phase_next = PH_SW1;
                state_next = S_ZRD;
            end
            S_ZRD: begin
                state_next = S_EX;
            end
            S_EX: begin
                unique case (phase_reg)
                    PH_CMD: begin
                        havepick_next = 1'b1;
                        pick_next     = zaddr_reg;
                        capout_next   = rec.free_blocks;
                        state_next    = S_DONE;
                        priority if (req_reg.command == zap_pkg::CMD_APPEND) begin
                            if (rec.free_blocks < req_reg.block_count) begin
                                status_next = zap_pkg::ST_NO_SPACE;
                            end else begin
                                wsum = {1'b0, rec.written_blocks} + {1'b0, req_reg.block_count};
                                wrec.written_blocks = wsum[zap_pkg::CAP_W] ? zap_pkg::CAP_MAX :
                                                      wsum[zap_pkg::CAP_W-1:0];
                                wrec.free_blocks = rec.free_blocks - req_reg.block_count;
                                capout_next      = wrec.free_blocks;
                                zwe              = 1'b1;
                            end
                        end else if (req_reg.command == zap_pkg::CMD_CLOSE) begin
                            if (!rec.open_flag) begin
                                status_next = zap_pkg::ST_BAD;
                            end else begin
                                wrec.open_flag = 1'b0;
                                zwe            = 1'b1;
                                open_next      = zap_pkg::sat_dec(open_reg);
                                if (rec.free_blocks == '0) begin
                                    active_next = zap_pkg::sat_dec(active_reg);
                                end
                            end
                        end else begin
                            wrec.used_blocks = req_reg.block_count;
                            zwe              = 1'b1;
                        end
                    end
                    PH_RST: begin
                        if (rec.used_blocks == '0 && !rec.open_flag &&
                            rec.written_blocks != '0) begin
                            if (rec.free_blocks != '0) begin
                                active_next = zap_pkg::sat_dec(active_reg);
                            end
                            wrec.prot_flag      = 1'b0;
                            wrec.free_blocks    = cfg.zone_capacity;
                            wrec.written_blocks = '0;
                            wrec.lifetime       = '0;
                            zwe                 = 1'b1;
                        end
                        if (last) begin
                            state_next = S_DONE;
                        end else begin
                            zaddr_next = zaddr_reg + zap_pkg::ZONE_W'(1);
                            state_next = S_ZRD;
                        end
                    end
                    PH_SW1: begin
                        if (!(rec.open_flag || rec.written_blocks == '0 ||
                              (rec.free_blocks == '0 && rec.used_blocks != '0))) begin
                            if (rec.used_blocks == '0) begin
                                if (rec.free_blocks != '0) begin
                                    active_next = zap_pkg::sat_dec(active_reg);
                                end
                                wrec.prot_flag      = 1'b0;
                                wrec.free_blocks    = cfg.zone_capacity;
                                wrec.written_blocks = '0;
                                wrec.lifetime       = '0;
                                zwe                 = 1'b1;
                            end else begin
                                if ({1'b0, rec.free_blocks} < thr_reg) begin
                                    nf                  = '0;
                                    wrec.free_blocks    = '0;
                                    wrec.written_blocks = cfg.zone_capacity;
                                    zwe                 = 1'b1;
                                    active_next         = zap_pkg::sat_dec(active_reg);
                                end
                                if (nf != '0 && (!hv_reg || vfree_reg > nf)) begin
                                    victim_next = zaddr_reg;
                                    vfree_next  = nf;
                                    hv_next     = 1'b1;
                                end
                            end
                        end
                        if (last) begin
                            zaddr_next = '0;
                            if (req_reg.protected_request) begin
                                idx_next   = '0;
                                phase_next = PH_PLIST;
                                state_next = (plen_reg == '0) ? S_POST : S_ORD;
                            end else begin
                                best_next  = zap_pkg::DIFF_BAD;
                                phase_next = PH_LIFE;
                                state_next = S_ZRD;
                            end
                        end else begin
                            zaddr_next = zaddr_reg + zap_pkg::ZONE_W'(1);
                            state_next = S_ZRD;
                        end
                    end
                    PH_PLIST: begin
                        if (!rec.open_flag && rec.used_blocks != '0 &&
                            rec.free_blocks != '0) begin
                            wrec.prot_flag = 1'b1;
                            zwe            = 1'b1;
                            pick_next      = zaddr_reg;
                            found_next     = 1'b1;
                            state_next     = S_FIN;
                        end else begin
                            if (rec.free_blocks == '0) begin
                                flush_next     = 1'b1;
                                wrec.prot_flag = 1'b0;
                                zwe            = 1'b1;
                            end
                            if (idx_reg + zap_pkg::CNT_W'(1) == plen_reg) begin
                                state_next = S_POST;
                            end else begin
                                idx_next   = idx_reg + zap_pkg::CNT_W'(1);
                                state_next = S_ORD;
                            end
                        end
                    end
                    PH_PCLR: begin
                        wrec.prot_flag = 1'b0;
                        zwe            = 1'b1;
                        if (idx_reg + zap_pkg::CNT_W'(1) == plen_reg) begin
                            plen_next  = '0;
                            state_next = S_VCHK;
                        end else begin
                            idx_next   = idx_reg + zap_pkg::CNT_W'(1);
                            state_next = S_ORD;
                        end
                    end
                    PH_VIC: begin
                        wrec.free_blocks    = '0;
                        wrec.written_blocks = cfg.zone_capacity;
                        zwe                 = 1'b1;
                        active_next         = zap_pkg::sat_dec(active_reg);
                        state_next          = S_ECHK;
                    end
                    PH_LIFE: begin
                        if (!rec.open_flag && rec.used_blocks != '0 &&
                            rec.free_blocks != '0) begin
                            d = zap_pkg::lifetime_diff(rec.lifetime, req_reg.lifetime_hint);
                            if (d <= best_reg) begin
                                pick_next  = zaddr_reg;
                                bnew       = d;
                                found_next = 1'b1;
                            end
                        end
                        best_next = bnew;
                        if (last) begin
                            state_next = (bnew >= zap_pkg::DIFF_BAD) ? S_VCHK : S_FIN;
                        end else begin
                            zaddr_next = zaddr_reg + zap_pkg::ZONE_W'(1);
                            state_next = S_ZRD;
                        end
                    end
                    PH_EMPTY: begin
                        if (!rec.open_flag && rec.written_blocks == '0) begin
                            wrec.lifetime = req_reg.lifetime_hint;
                            active_next   = zap_pkg::sat_inc(active_reg);
                            if (req_reg.protected_request) begin
                                wrec.prot_flag = 1'b1;
                                if (plen_reg < zap_pkg::ZONE_TOTAL) begin
                                    owe       = 1'b1;
                                    plen_next = plen_reg + zap_pkg::CNT_W'(1);
                                end
                            end
                            zwe        = 1'b1;
                            pick_next  = zaddr_reg;
                            found_next = 1'b1;
                            fresh_next = 1'b1;
                            state_next = S_FIN;
                        end else if (last) begin
                            state_next = S_FIN;
                        end else begin
                            zaddr_next = zaddr_reg + zap_pkg::ZONE_W'(1);
                            state_next = S_ZRD;
                        end
                    end
                    PH_OPEN: begin
                        wrec.open_flag = 1'b1;
                        zwe            = 1'b1;
                        open_next      = zap_pkg::sat_inc(open_reg);
                        capout_next    = rec.free_blocks;
                        havepick_next  = 1'b1;
                        status_next    = zap_pkg::ST_OK;
                        state_next     = S_DONE;
                    end
                    default: begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_ORD: begin
                state_next = S_ORDW;
            end
            S_ORDW: begin
                zaddr_next = ord_rd_data;
                state_next = S_ZRD;
            end
            S_POST: begin
                // list gave nothing: flush it once it has reached its limit
                if (plen_reg == cfg.protected_zone_limit) begin
                    flush_next = 1'b1;
                    if (plen_reg != '0) begin
                        idx_next   = '0;
                        phase_next = PH_PCLR;
                        state_next = S_ORD;
                    end else begin
                        state_next = S_VCHK;
                    end
                end else begin
                    state_next = S_VCHK;
                end
            end
            S_VCHK: begin
                if (active_reg == cfg.max_active_zones && hv_reg) begin
                    zaddr_next = victim_reg;
                    phase_next = PH_VIC;
                    state_next = S_ZRD;
                end else begin
                    state_next = S_ECHK;
                end
            end
            S_ECHK: begin
                if (active_reg >= cfg.max_active_zones) begin
                    state_next = S_FIN;
                end else begin
                    zaddr_next = '0;
                    phase_next = PH_EMPTY;
                    state_next = S_ZRD;
                end
            end
            S_FIN: begin
                if (found_reg) begin
                    zaddr_next = pick_reg;
                    phase_next = PH_OPEN;
                    state_next = S_ZRD;
                end else begin
                    status_next   = zap_pkg::ST_NO_ZONE;
                    havepick_next = 1'b0;
                    state_next    = S_DONE;
                end
            end
            S_DONE: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            phase_reg  <= PH_CMD;
            active_reg <= '0;
            open_reg   <= '0;
            plen_reg   <= '0;
        end else begin
            state_reg  <= state_next;
            phase_reg  <= phase_next;
            active_reg <= active_next;
            open_reg   <= open_next;
            plen_reg   <= plen_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg      <= req_next;
        zaddr_reg    <= zaddr_next;
        idx_reg      <= idx_next;
        victim_reg   <= victim_next;
        vfree_reg    <= vfree_next;
        hv_reg       <= hv_next;
        pick_reg     <= pick_next;
        found_reg    <= found_next;
        fresh_reg    <= fresh_next;
        flush_reg    <= flush_next;
        havepick_reg <= havepick_next;
        best_reg     <= best_next;
        thr_reg      <= thr_next;
        prod_reg     <= prod_next;
        status_reg   <= status_next;
        capout_reg   <= capout_next;
    end
endmodule
`default_nettype wire

// ----- tb/tb_zone_allocation_policy_core.sv -----
// Testbench of the zone allocation policy core: directed table, then random words.
`timescale 1ns / 1ps
module tb_zone_allocation_policy_core;
    import zap_pkg::*;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic [2:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;
    logic        cfg_wr_en;
    logic [2:0]  cfg_index;
    logic [20:0] cfg_wdata;

    zone_allocation_policy_core u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    typedef struct {
        req_t    r;
        bit      typed;
        result_t res;
    } dir_row_t;

    // shadow configuration
    logic [CNT_W-1:0] thr_pct, lim_active, lim_open, prot_limit;
    logic [CAP_W-1:0] zone_cap;

    // shadow zone state
    logic [CAP_W-1:0]  free_blk [ZONE_COUNT];
    logic [CAP_W-1:0]  wr_blk   [ZONE_COUNT];
    logic [CAP_W-1:0]  used_blk [ZONE_COUNT];
    logic              is_open  [ZONE_COUNT];
    logic [HINT_W-1:0] life     [ZONE_COUNT];
    logic              is_prot  [ZONE_COUNT];
    logic [ZONE_W-1:0] prot_list[ZONE_COUNT];
    int                prot_len;
    logic [CNT_W-1:0]  n_active, n_open;

    result_t pending_results[$];
    int      errors;
    int      tx_pct, rx_pct, hold_left;
    bit      cur_typed;
    result_t cur_res;
    logic [ZONE_W-1:0] last_alloc;

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #10_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic void shadow_reset();
        thr_pct = 0; lim_active = 64; lim_open = 64; prot_limit = 0; zone_cap = 1048576;
        for (int z = 0; z < ZONE_COUNT; z++) begin
            free_blk[z] = 1048576; wr_blk[z] = 0; used_blk[z] = 0;
            is_open[z] = 0; life[z] = 0; is_prot[z] = 0; prot_list[z] = 0;
        end
        prot_len = 0; n_active = 0; n_open = 0;
    endfunction

    function automatic void active_down();
        if (n_active != 0) n_active--;
    endfunction

    function automatic void wipe_zone(int z);
        is_prot[z] = 0; free_blk[z] = zone_cap; wr_blk[z] = 0; life[z] = 0;
    endfunction

    function automatic void close_out_zone(int z);
        free_blk[z] = 0; wr_blk[z] = zone_cap;
    endfunction

    function automatic int hint_distance(logic [HINT_W-1:0] zl, logic [HINT_W-1:0] fl);
        if (fl <= 1) return (fl == zl) ? 0 : 100;
        if (zl > fl) return zl - fl;
        return 100;
    endfunction

    function automatic bit grab_empty(output int pick, input logic [HINT_W-1:0] hint,
                                      input bit prot);
        pick = 0;
        if (n_active >= lim_active) return 0;
        for (int z = 0; z < ZONE_COUNT; z++) begin
            if (!is_open[z] && wr_blk[z] == 0) begin
                life[z] = hint;
                if (n_active != CNT_MAX) n_active++;
                if (prot) begin
                    is_prot[z] = 1;
                    if (prot_len < ZONE_COUNT) begin
                        prot_list[prot_len] = z;
                        prot_len++;
                    end
                end
                pick = z;
                return 1;
            end
        end
        return 0;
    endfunction

    function automatic logic [STAT_W-1:0] allocate_zone(input logic [HINT_W-1:0] hint,
            input bit prot, output int pick, output bit fresh, output bit flush);
        int victim, z, best, d;
        bit have_victim, found;
        longint limit_blk;
        victim = 0; have_victim = 0; found = 0; pick = 0; fresh = 0; flush = 0;
        if (n_open >= lim_open) return ST_OPEN_LIMIT;
        limit_blk = (longint'(zone_cap) * longint'(thr_pct)) / 100;
        for (z = 0; z < ZONE_COUNT; z++) begin
            if (is_open[z] || wr_blk[z] == 0 || (free_blk[z] == 0 && used_blk[z] > 0))
                continue;
            if (used_blk[z] == 0) begin
                if (free_blk[z] != 0) active_down();
                wipe_zone(z);
                continue;
            end
            if (longint'(free_blk[z]) < limit_blk) begin
                close_out_zone(z);
                active_down();
            end
            if (free_blk[z] != 0 && (!have_victim || free_blk[victim] > free_blk[z])) begin
                victim = z;
                have_victim = 1;
            end
        end
        if (prot) begin
            for (int i = 0; i < prot_len; i++) begin
                z = prot_list[i];
                if (!is_open[z] && used_blk[z] > 0 && free_blk[z] != 0) begin
                    is_prot[z] = 1;
                    pick = z;
                    found = 1;
                    break;
                end else if (free_blk[z] == 0) begin
                    flush = 1;
                    is_prot[z] = 0;
                end
            end
            if (!found) begin
                if (prot_len == prot_limit) begin
                    flush = 1;
                    for (int i = 0; i < prot_len; i++) is_prot[prot_list[i]] = 0;
                    prot_len = 0;
                end
                if (n_active == lim_active && have_victim) begin
                    close_out_zone(victim);
                    active_down();
                end
                found = grab_empty(pick, hint, 1);
                fresh = found;
            end
        end else begin
            best = 100;
            for (z = 0; z < ZONE_COUNT; z++) begin
                if (!is_open[z] && used_blk[z] > 0 && free_blk[z] != 0) begin
                    d = hint_distance(life[z], hint);
                    if (d <= best) begin
                        pick = z; best = d; found = 1;
                    end
                end
            end
            if (best >= 100) begin
                if (n_active == lim_active && have_victim) begin
                    close_out_zone(victim);
                    active_down();
                end
                if (grab_empty(pick, hint, 0)) begin
                    found = 1;
                    fresh = 1;
                end
            end
        end
        if (!found) return ST_NO_ZONE;
        is_open[pick] = 1;
        if (n_open != CNT_MAX) n_open++;
        return ST_OK;
    endfunction

    function automatic result_t zone_outcome(req_t r);
        result_t o;
        int pick, z;
        bit have, fresh, flush;
        logic [STAT_W-1:0] st;
        pick = 0; have = 0; fresh = 0; flush = 0; st = ST_OK;
        if (r.command == CMD_ALLOC) begin
            if (r.lifetime_hint > HINT_MAX) begin
                st = ST_BAD;
            end else begin
                st = allocate_zone(r.lifetime_hint, r.protected_request, pick, fresh, flush);
                have = (st == ST_OK);
            end
        end else if (r.command == CMD_APPEND || r.command == CMD_CLOSE ||
                     r.command == CMD_SET_USED) begin
            z = r.zone_index;
            pick = z;
            have = 1;
            if (r.command == CMD_APPEND) begin
                if (free_blk[z] < r.block_count) begin
                    st = ST_NO_SPACE;
                end else begin
                    wr_blk[z] = (int'(wr_blk[z]) + int'(r.block_count) > int'(CAP_MAX))
                        ? CAP_MAX : wr_blk[z] + r.block_count;
                    free_blk[z] = free_blk[z] - r.block_count;
                end
            end else if (r.command == CMD_CLOSE) begin
                if (!is_open[z]) begin
                    st = ST_BAD;
                end else begin
                    is_open[z] = 0;
                    if (n_open != 0) n_open--;
                    if (free_blk[z] == 0) active_down();
                end
            end else begin
                used_blk[z] = r.block_count;
            end
        end else if (r.command == CMD_RESET_UNU) begin
            for (z = 0; z < ZONE_COUNT; z++) begin
                if (used_blk[z] == 0 && !is_open[z] && wr_blk[z] != 0) begin
                    if (free_blk[z] != 0) active_down();
                    wipe_zone(z);
                end
            end
        end else begin
            st = ST_BAD;
        end
        o.status = st;
        o.chosen_zone = have ? ZONE_W'(pick) : '0;
        o.was_empty_zone = fresh;
        o.flush_issued = flush;
        o.capacity_left = have ? free_blk[pick] : '0;
        o.active_count = n_active;
        o.open_count = n_open;
        return o;
    endfunction

    task automatic report(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    // accept side: predict on each input word, check each output word
    always @(posedge aclk) begin
        result_t want, got;
        req_t    r;
        if (aresetn && s_tvalid && s_tready) begin
            r.command = s_tuser;
            r.lifetime_hint = s_tdata[2:0];
            r.protected_request = s_tdata[3];
            r.zone_index = s_tdata[9:4];
            r.block_count = s_tdata[30:10];
            want = zone_outcome(r);
            if (want.status == ST_OK && r.command == CMD_ALLOC) last_alloc = want.chosen_zone;
            pending_results.push_back(cur_typed ? cur_res : want);
        end
        if (aresetn && m_tvalid && m_tready) begin
            got.status = m_tdata[2:0];
            got.chosen_zone = m_tdata[8:3];
            got.was_empty_zone = m_tdata[9];
            got.flush_issued = m_tdata[10];
            got.capacity_left = m_tdata[31:11];
            got.active_count = m_tdata[38:32];
            got.open_count = m_tdata[45:39];
            if (pending_results.size() == 0) begin
                report("unexpected word", 0, 0);
            end else begin
                want = pending_results.pop_front();
                if (got.status != want.status) report("status", got.status, want.status);
                if (got.chosen_zone != want.chosen_zone)
                    report("chosen_zone", got.chosen_zone, want.chosen_zone);
                if (got.was_empty_zone != want.was_empty_zone)
                    report("was_empty_zone", got.was_empty_zone, want.was_empty_zone);
                if (got.flush_issued != want.flush_issued)
                    report("flush_issued", got.flush_issued, want.flush_issued);
                if (got.capacity_left != want.capacity_left)
                    report("capacity_left", got.capacity_left, want.capacity_left);
                if (got.active_count != want.active_count)
                    report("active_count", got.active_count, want.active_count);
                if (got.open_count != want.open_count)
                    report("open_count", got.open_count, want.open_count);
            end
        end
    end

    // receiver: a long hold-off takes priority over random stalls
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready = 1'b0;
        end else if (hold_left > 0) begin
            m_tready = 1'b0;
            hold_left--;
        end else begin
            m_tready = ($urandom_range(99) >= rx_pct);
        end
    end

    task automatic send_word(req_t r, bit typed, result_t res);
        while ($urandom_range(99) < tx_pct) @(negedge aclk);
        s_tvalid = 1'b1;
        s_tuser = r.command;
        s_tdata = {1'b0, r.block_count, r.zone_index, r.protected_request, r.lifetime_hint};
        cur_typed = typed;
        cur_res = res;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        s_tvalid = 1'b0;
        cur_typed = 1'b0;
    endtask

    task automatic write_reg(logic [2:0] idx, logic [20:0] val);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wdata = val;
        case (idx)
            REG_FINISH_THR: thr_pct = val[6:0];
            REG_MAX_ACTIVE: lim_active = val[6:0];
            REG_MAX_OPEN:   lim_open = val[6:0];
            REG_PROT_LIMIT: prot_limit = val[6:0];
            default:        zone_cap = val;
        endcase
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    task automatic drain();
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic set_phase(int thr, int act, int opn, int plim, int cap, int mode);
        drain();
        write_reg(REG_FINISH_THR, thr);
        write_reg(REG_MAX_ACTIVE, act);
        write_reg(REG_MAX_OPEN, opn);
        write_reg(REG_PROT_LIMIT, plim);
        write_reg(REG_ZONE_CAP, cap);
        tx_pct = (mode == 1 || mode == 3) ? ((mode == 3) ? 23 : 57) : 0;
        rx_pct = (mode == 2 || mode == 3) ? ((mode == 3) ? 23 : 57) : 0;
    endtask

    function automatic req_t random_word();
        req_t r;
        int pick;
        pick = $urandom_range(99);
        r.lifetime_hint = ($urandom_range(19) == 0) ? $urandom_range(7) : $urandom_range(5);
        r.protected_request = $urandom_range(1);
        r.zone_index = ($urandom_range(9) == 0) ? $urandom_range(63) : $urandom_range(11);
        if ($urandom_range(9) == 0) r.block_count = $urandom_range(21'h1FFFFF);
        else r.block_count = $urandom_range(0, zone_cap / 3 + 1);
        if (pick < 25) begin
            r.command = CMD_ALLOC;
        end else if (pick < 55) begin
            r.command = CMD_APPEND;
            if ($urandom_range(3) == 0) r.zone_index = last_alloc;
        end else if (pick < 70) begin
            r.command = CMD_CLOSE;
            if ($urandom_range(2) != 0) r.zone_index = last_alloc;
        end else if (pick < 90) begin
            r.command = CMD_SET_USED;
            if ($urandom_range(2) == 0) r.block_count = 0;
        end else if (pick < 95) begin
            r.command = CMD_RESET_UNU;
        end else begin
            r.command = $urandom_range(5, 7);
        end
        return r;
    endfunction

    task automatic random_run(int n);
        result_t none;
        none = '0;
        repeat (n) send_word(random_word(), 1'b0, none);
    endtask

    initial begin
        dir_row_t rows[$];
        dir_row_t row;
        aresetn = 1'b0;
        s_tvalid = 1'b0; s_tdata = '0; s_tuser = '0;
        m_tready = 1'b0;
        cfg_wr_en = 1'b0; cfg_index = '0; cfg_wdata = '0;
        errors = 0; tx_pct = 0; rx_pct = 0; hold_left = 0;
        cur_typed = 1'b0; cur_res = '0; last_alloc = '0;
        shadow_reset();
        repeat (10) @(negedge aclk);
        aresetn = 1'b1;

        // command, hint, protected, zone, blocks | typed, expected word
        rows = '{
            '{'{3'd5, 3'd0, 1'b0, 6'd0, 21'd0}, 1'b1, '{ST_BAD, 6'd0, 1'b0, 1'b0, 21'd0, 7'd0, 7'd0}},
            '{'{3'd7, 3'd7, 1'b1, 6'd63, 21'h1FFFFF}, 1'b1,
              '{ST_BAD, 6'd0, 1'b0, 1'b0, 21'd0, 7'd0, 7'd0}},
            '{'{CMD_ALLOC, 3'd6, 1'b0, 6'd0, 21'd0}, 1'b1,
              '{ST_BAD, 6'd0, 1'b0, 1'b0, 21'd0, 7'd0, 7'd0}},
            '{'{CMD_APPEND, 3'd0, 1'b0, 6'd0, 21'd0}, 1'b1,
              '{ST_OK, 6'd0, 1'b0, 1'b0, 21'd1048576, 7'd0, 7'd0}},
            '{'{CMD_CLOSE, 3'd0, 1'b0, 6'd5, 21'd0}, 1'b1,
              '{ST_BAD, 6'd5, 1'b0, 1'b0, 21'd1048576, 7'd0, 7'd0}},
            '{'{CMD_ALLOC, 3'd0, 1'b0, 6'd0, 21'd0}, 1'b1,
              '{ST_OK, 6'd0, 1'b1, 1'b0, 21'd1048576, 7'd1, 7'd1}},
            '{'{CMD_APPEND, 3'd0, 1'b0, 6'd0, 21'h1FFFFF}, 1'b1,
              '{ST_NO_SPACE, 6'd0, 1'b0, 1'b0, 21'd1048576, 7'd1, 7'd1}},
            '{'{CMD_APPEND, 3'd0, 1'b0, 6'd0, 21'd1000}, 1'b0, '0},
            '{'{CMD_SET_USED, 3'd0, 1'b0, 6'd0, 21'd500}, 1'b0, '0},
            '{'{CMD_CLOSE, 3'd0, 1'b0, 6'd0, 21'd0}, 1'b0, '0},
            '{'{CMD_ALLOC, 3'd5, 1'b1, 6'd0, 21'd0}, 1'b0, '0},
            '{'{CMD_APPEND, 3'd0, 1'b0, 6'd1, 21'd1048576}, 1'b0, '0},
            '{'{CMD_SET_USED, 3'd0, 1'b0, 6'd1, 21'h1FFFFF}, 1'b0, '0},
            '{'{CMD_CLOSE, 3'd0, 1'b0, 6'd1, 21'd0}, 1'b0, '0},
            '{'{CMD_ALLOC, 3'd2, 1'b0, 6'd0, 21'd0}, 1'b0, '0},
            '{'{CMD_ALLOC, 3'd1, 1'b1, 6'd0, 21'd0}, 1'b0, '0},
            '{'{CMD_APPEND, 3'd0, 1'b0, 6'd63, 21'd7}, 1'b0, '0},
            '{'{CMD_SET_USED, 3'd0, 1'b0, 6'd0, 21'd0}, 1'b0, '0},
            '{'{CMD_RESET_UNU, 3'd0, 1'b0, 6'd0, 21'd0}, 1'b0, '0},
            '{'{CMD_ALLOC, 3'd4, 1'b0, 6'd0, 21'd0}, 1'b0, '0}
        };
        foreach (rows[i]) begin
            row = rows[i];
            send_word(row.r, row.typed, row.res);
        end

        // tight limits first so the open limit and finish victim show up
        set_phase(0, 1, 1, 64, 1, 0);
        random_run(60);
        set_phase(100, 64, 64, 0, 64, 1);
        random_run(80);
        set_phase(50, 3, 2, 2, 1000, 2);
        random_run(80);
        set_phase(30, 8, 5, 3, 21'h1FFFFF, 3);
        random_run(80);
        // hold the receiver off so the input stalls behind a full output
        set_phase(10, 64, 64, 1, 300, 0);
        hold_left = 3000;
        random_run(80);
        set_phase(127, 127, 127, 127, 1048576, 1);
        random_run(70);

        drain();
        repeat (500) @(negedge aclk);
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/zap_pkg.sv
rtl/core/zap_ram.sv
rtl/core/zap_zone_store.sv
rtl/core/zap_ctrl.sv
rtl/core/zone_allocation_policy_core.sv
tb/tb_zone_allocation_policy_core.sv
